// ===== src/atc_pkg.sv =====
`default_nettype none
package atc_pkg;

  localparam int NAME_CHARS = 5;
  localparam int NAME_COUNT = 31;

  localparam logic MODE_CHAR = 1'b0;
  localparam logic MODE_END  = 1'b1;

  localparam logic [5:0] KIND_LABEL  = 6'd0;
  localparam logic [5:0] KIND_NUMBER = 6'd1;
  localparam logic [5:0] KIND_TEXT   = 6'd2;
  localparam logic [5:0] KIND_OPEND  = 6'd3;
  localparam logic [5:0] KIND_ERROR  = 6'd35;
  localparam logic [5:0] KIND_END    = 6'd36;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBR    = 8'h5B;
  localparam logic [7:0] CH_RBR    = 8'h5D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_code;
  } src_word_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] token_start;
    logic [7:0]  token_length;
    logic        success;
    logic        last_of_run;
  } res_word_t;

  // results produced by one source word, in order, res[0] first
  typedef struct packed {
    logic [1:0]            count;
    res_word_t [2:0]       res;
  } atc_batch_t;

  typedef struct packed {
    logic over;
    logic pre_valid;
    logic all_valid;
    logic all_digit;
    logic first_alpha;
    logic first_lbr;
    logic last_rbr;
    logic last_colon;
  } tok_flags_t;

  // text: first character in the top byte, padded with spaces
  typedef struct packed {
    logic [8*NAME_CHARS-1:0] text;
    logic [2:0]              len;
    logic [5:0]              kind;
  } name_entry_t;

  localparam name_entry_t NAME_TABLE [NAME_COUNT] = '{
    '{"A    ", 3'd1, 6'd4},  '{"B    ", 3'd1, 6'd5},  '{"C    ", 3'd1, 6'd6},
    '{"SP   ", 3'd2, 6'd7},  '{"[A]  ", 3'd3, 6'd8},  '{"[B]  ", 3'd3, 6'd9},
    '{"[C]  ", 3'd3, 6'd10}, '{"[SP] ", 3'd4, 6'd11}, '{"NOP  ", 3'd3, 6'd12},
    '{"CONST", 3'd5, 6'd13}, '{"DAT  ", 3'd3, 6'd14}, '{"MOV  ", 3'd3, 6'd15},
    '{"LOAD ", 3'd4, 6'd16}, '{"PUSH ", 3'd4, 6'd17}, '{"POP  ", 3'd3, 6'd18},
    '{"CMP  ", 3'd3, 6'd19}, '{"INC  ", 3'd3, 6'd20}, '{"DEC  ", 3'd3, 6'd21},
    '{"ADD  ", 3'd3, 6'd22}, '{"SUB  ", 3'd3, 6'd23}, '{"MUL  ", 3'd3, 6'd24},
    '{"DIV  ", 3'd3, 6'd25}, '{"MOD  ", 3'd3, 6'd26}, '{"AND  ", 3'd3, 6'd27},
    '{"OR   ", 3'd2, 6'd28}, '{"XOR  ", 3'd3, 6'd29}, '{"NOT  ", 3'd3, 6'd30},
    '{"JMP  ", 3'd3, 6'd31}, '{"JE   ", 3'd2, 6'd32}, '{"JG   ", 3'd2, 6'd33},
    '{"JL   ", 3'd2, 6'd34}
  };

endpackage
`default_nettype wire

// ===== src/atc_lexer.sv =====
`default_nettype none
module atc_lexer import atc_pkg::*; #(
  parameter int POSITION_BITS = 16,
  parameter int LENGTH_LIMIT  = 255
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       src_valid,
  output logic            src_stall,
  input  wire src_word_t  src_word,
  input  wire logic       room,
  output atc_batch_t      batch
);

  localparam int LW = $clog2(LENGTH_LIMIT + 1);

  function automatic logic [6:0] lookup(input logic [NAME_CHARS-1:0][7:0] pre,
                                        input logic [2:0] len);
    logic       hit;
    logic       eq;
    logic [5:0] kind;
    hit  = 1'b0;
    kind = 6'd0;
    for (int i = 0; i < NAME_COUNT; i++) begin
      eq = (NAME_TABLE[i].len == len);
      for (int j = 0; j < NAME_CHARS; j++) begin
        if (j < int'(NAME_TABLE[i].len) &&
            pre[j] != NAME_TABLE[i].text[8*(NAME_CHARS-1-j) +: 8]) begin
          eq = 1'b0;
        end
      end
      if (eq && !hit) begin
        hit  = 1'b1;
        kind = NAME_TABLE[i].kind;
      end
    end
    return {hit, kind};
  endfunction

  logic                          full;
  src_word_t                     word;
  logic [NAME_CHARS-1:0][7:0]    prefix, prefix_next;
  logic [LW-1:0]                 cur_len, cur_len_next;
  logic [POSITION_BITS-1:0]      start_pos, start_pos_next;
  logic [POSITION_BITS-1:0]      char_pos, char_pos_next;
  tok_flags_t                    tflags, tflags_next;
  logic                          in_token, in_token_next;
  logic                          dead, dead_next;
  logic                          nonempty, nonempty_next;
  logic                          prev_label, prev_label_next;
  logic                          err_seen, err_seen_next;

  logic                          process;
  logic [6:0]                    lk;
  logic                          hit;
  logic [5:0]                    fin_kind;
  logic [LW-1:0]                 fin_len;
  logic                          fin_label, fin_err;
  logic                          va, vb, vc, ok;
  logic [7:0]                    c;
  logic                          c_digit, c_alpha, c_valid, c_print, c_space;
  res_word_t                     ra, rb, rc;

  assign process   = full && room;
  assign src_stall = full && !room;
  assign c         = word.char_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (!src_stall) begin
      full <= src_valid;
    end
    if (!src_stall && src_valid) begin
      word <= src_word;
    end
  end

  always_comb begin
    c_digit = (c >= "0") && (c <= "9");
    c_alpha = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    c_valid = c_digit || c_alpha || (c == CH_UNDER);
    c_print = (c >= 8'h21) && (c <= 8'h7E);
    c_space = (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
  end

  // classification of the token in progress
  always_comb begin
    lk  = lookup(prefix, cur_len[2:0]);
    hit = lk[6] && !tflags.over && (cur_len <= LW'(NAME_CHARS));
    if (tflags.last_colon) begin
      fin_kind = tflags.pre_valid ? KIND_LABEL : KIND_ERROR;
    end else if (tflags.first_lbr && tflags.last_rbr) begin
      fin_kind = hit ? lk[5:0] : KIND_ERROR;
    end else if (tflags.all_digit) begin
      fin_kind = KIND_NUMBER;
    end else if (tflags.first_alpha && tflags.all_valid) begin
      fin_kind = hit ? lk[5:0] : KIND_TEXT;
    end else begin
      fin_kind = KIND_ERROR;
    end
    fin_label = (fin_kind == KIND_LABEL);
    fin_err   = (fin_kind == KIND_ERROR);
    fin_len   = (fin_label && !tflags.over && cur_len != '0) ? cur_len - 1'b1 : cur_len;
  end

  always_comb begin
    prefix_next     = prefix;
    cur_len_next    = cur_len;
    start_pos_next  = start_pos;
    char_pos_next   = char_pos;
    tflags_next     = tflags;
    in_token_next   = in_token;
    dead_next       = dead;
    nonempty_next   = nonempty;
    prev_label_next = prev_label;
    err_seen_next   = err_seen;
    va = 1'b0;
    vb = 1'b0;
    vc = 1'b0;
    ok = 1'b0;
    if (process) begin
      if (word.mode == MODE_END) begin
        va = !err_seen && in_token;
        ok = !(err_seen || (va && fin_err));
        vb = ok && nonempty && !(va ? fin_label : prev_label);
        vc = 1'b1;
        prefix_next     = '0;
        cur_len_next    = '0;
        start_pos_next  = '0;
        char_pos_next   = '0;
        tflags_next     = '0;
        in_token_next   = 1'b0;
        dead_next       = 1'b0;
        nonempty_next   = 1'b0;
        prev_label_next = 1'b0;
        err_seen_next   = 1'b0;
      end else begin
        if (!err_seen) begin
          nonempty_next = 1'b1;
          if (dead) begin
            if (c == CH_LF) begin
              vb            = !prev_label;
              in_token_next = 1'b0;
              dead_next     = 1'b0;
              nonempty_next = 1'b0;
            end
          end else if (c_print) begin
            if (!in_token) begin
              in_token_next        = 1'b1;
              start_pos_next       = char_pos;
              cur_len_next         = '0;
              tflags_next          = '0;
              tflags_next.all_valid   = 1'b1;
              tflags_next.all_digit   = 1'b1;
              tflags_next.first_lbr   = (c == CH_LBR);
              tflags_next.first_alpha = c_alpha;
            end
            tflags_next.pre_valid  = tflags_next.all_valid;
            tflags_next.last_colon = (c == CH_COLON);
            tflags_next.last_rbr   = (c == CH_RBR);
            if (!c_valid) tflags_next.all_valid = 1'b0;
            if (!c_digit) tflags_next.all_digit = 1'b0;
            if (cur_len_next < LW'(NAME_CHARS)) begin
              prefix_next[cur_len_next[2:0]] = c;
            end
            if (cur_len_next >= LW'(LENGTH_LIMIT)) begin
              tflags_next.over = 1'b1;
            end else begin
              cur_len_next = cur_len_next + 1'b1;
            end
          end else begin
            va = in_token;
            if (in_token) begin
              in_token_next   = 1'b0;
              prev_label_next = fin_label;
              err_seen_next   = fin_err;
            end
            if (!(va && fin_err)) begin
              if (c == CH_LF) begin
                vb            = !(va ? fin_label : prev_label);
                in_token_next = 1'b0;
                dead_next     = 1'b0;
                nonempty_next = 1'b0;
              end else if (!c_space) begin
                dead_next = 1'b1;
              end
            end
          end
        end
        char_pos_next = char_pos + 1'b1;
      end
    end
  end

  always_comb begin
    ra.kind         = fin_kind;
    ra.token_start  = 16'(start_pos);
    ra.token_length = 8'(fin_len);
    ra.success      = 1'b0;
    ra.last_of_run  = !vb && !vc;
    rb.kind         = KIND_OPEND;
    rb.token_start  = 16'(char_pos);
    rb.token_length = 8'd0;
    rb.success      = 1'b0;
    rb.last_of_run  = !vc;
    rc.kind         = KIND_END;
    rc.token_start  = 16'(char_pos);
    rc.token_length = 8'd0;
    rc.success      = ok;
    rc.last_of_run  = 1'b1;
    batch.count  = 2'({1'b0, va} + {1'b0, vb} + {1'b0, vc});
    batch.res[0] = va ? ra : (vb ? rb : rc);
    batch.res[1] = va ? (vb ? rb : rc) : rc;
    batch.res[2] = rc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix     <= '0;
      cur_len    <= '0;
      start_pos  <= '0;
      char_pos   <= '0;
      tflags     <= '0;
      in_token   <= 1'b0;
      dead       <= 1'b0;
      nonempty   <= 1'b0;
      prev_label <= 1'b0;
      err_seen   <= 1'b0;
    end else begin
      prefix     <= prefix_next;
      cur_len    <= cur_len_next;
      start_pos  <= start_pos_next;
      char_pos   <= char_pos_next;
      tflags     <= tflags_next;
      in_token   <= in_token_next;
      dead       <= dead_next;
      nonempty   <= nonempty_next;
      prev_label <= prev_label_next;
      err_seen   <= err_seen_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/atc_fifo.sv =====
`default_nettype none
module atc_fifo import atc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire atc_batch_t batch,
  output logic            room,
  output logic            res_valid,
  input  wire logic       res_stall,
  output res_word_t       res_word
);

  res_word_t  q [4];
  logic [1:0] wptr, rptr;
  logic [2:0] count;
  logic       pop;

  assign room      = (count <= 3'd1);
  assign res_valid = (count != 3'd0);
  assign res_word  = q[rptr];
  assign pop       = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (i < int'(batch.count)) begin
        q[wptr + 2'(i)] <= batch.res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + batch.count;
      rptr  <= rptr + {1'b0, pop};
      count <= count + {1'b0, batch.count} - {2'b00, pop};
    end
  end

endmodule
`default_nettype wire

// ===== src/assembly_token_classifier.sv =====
// Throughput: one source word per cycle while res_stall is low and each word
// yields at most one result; words yielding two or three results hold the
// input until the 4-entry result queue, draining one word per cycle while
// res_stall is low, is back to at most one entry.
// Reset (rst, synchronous): clears the token/line state and empties the queue.
`default_nettype none
module assembly_token_classifier import atc_pkg::*; #(
  parameter int POSITION_BITS = 16,
  parameter int LENGTH_LIMIT  = 255
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      src_valid,
  output logic           src_stall,
  input  wire src_word_t src_word,
  output logic           res_valid,
  input  wire logic      res_stall,
  output res_word_t      res_word
);

  atc_batch_t batch;
  logic       room;

  atc_lexer #(
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_LIMIT  (LENGTH_LIMIT)
  ) u_lexer (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_word  (src_word),
    .room      (room),
    .batch     (batch)
  );

  atc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .batch     (batch),
    .room      (room),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import atc_pkg::*;

  localparam int LEN_CAP       = 255;
  localparam int PREFIX_LEN    = 5;
  localparam int NAME_TOTAL    = 31;
  localparam int RANDOM_ITEMS  = 90;
  localparam int CALM_AT       = RANDOM_ITEMS - 30;
  localparam int PAUSE_AT      = 40;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_MAX    = 10;
  localparam int PLAN_ROWS     = 25;

  localparam logic [5:0]  KIND_NAME_BASE = 6'd4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_TOP   = 8'hFF;
  localparam logic [7:0] CASE_BIT = 8'h20;

  typedef struct packed {
    logic      mode;
    logic [7:0] ch;
    logic      typed;
    res_word_t res;
  } plan_row_t;

  // typed rows: after reset, 0xFF terminator, error token, end after error
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{MODE_CHAR, "A",      1'b0, '0},
    '{MODE_CHAR, CH_COLON, 1'b0, '0},
    '{MODE_CHAR, CH_SPACE, 1'b1, '{KIND_LABEL, 16'd0, 8'd1, 1'b0, 1'b1}},
    '{MODE_CHAR, CH_LF,    1'b0, '0},
    '{MODE_CHAR, CH_LBR,   1'b0, '0},
    '{MODE_CHAR, "S",      1'b0, '0},
    '{MODE_CHAR, "P",      1'b0, '0},
    '{MODE_CHAR, CH_RBR,   1'b0, '0},
    '{MODE_CHAR, CH_TAB,   1'b0, '0},
    '{MODE_CHAR, "7",      1'b0, '0},
    '{MODE_CHAR, CH_LF,    1'b0, '0},
    '{MODE_CHAR, "J",      1'b0, '0},
    '{MODE_CHAR, "M",      1'b0, '0},
    '{MODE_CHAR, "P",      1'b0, '0},
    '{MODE_CHAR, CH_NUL,   1'b0, '0},
    '{MODE_CHAR, CH_DEL,   1'b0, '0},
    '{MODE_CHAR, CH_LF,    1'b0, '0},
    '{MODE_CHAR, "x",      1'b0, '0},
    '{MODE_CHAR, CH_TOP,   1'b1, '{KIND_TEXT, 16'd17, 8'd1, 1'b0, 1'b1}},
    '{MODE_END,  CH_NUL,   1'b0, '0},
    '{MODE_CHAR, CH_LBR,   1'b0, '0},
    '{MODE_CHAR, "Q",      1'b0, '0},
    '{MODE_CHAR, CH_RBR,   1'b0, '0},
    '{MODE_CHAR, CH_LF,    1'b1, '{KIND_ERROR, 16'd0, 8'd3, 1'b0, 1'b1}},
    '{MODE_END,  CH_TOP,   1'b1, '{KIND_END, 16'd4, 8'd0, 1'b0, 1'b1}}
  };

  string reg_op_names [NAME_TOTAL] = '{
    "A", "B", "C", "SP", "[A]", "[B]", "[C]", "[SP]", "NOP", "CONST", "DAT",
    "MOV", "LOAD", "PUSH", "POP", "CMP", "INC", "DEC", "ADD", "SUB", "MUL",
    "DIV", "MOD", "AND", "OR", "XOR", "NOT", "JMP", "JE", "JG", "JL"
  };

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      src_valid = 1'b0;
  logic      src_stall;
  src_word_t src_word = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_word_t res_word;

  assembly_token_classifier dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_word  (src_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // classifier state mirror
  logic [7:0]  prefix [PREFIX_LEN];
  int          tok_len;
  logic [15:0] tok_start;
  logic [15:0] char_pos;
  tok_flags_t  tf;
  bit          in_tok, line_dead, line_used, after_label, err_seen;

  res_word_t   step_out [$];
  res_word_t   token_queue [$];
  logic [7:0]  tok_bytes [$];

  int mismatches = 0;
  int src_count = 0;
  int gap_pct = 10;
  bit calm = 1'b0;
  bit counting = 1'b0;

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_word_char(input logic [7:0] c);
    return is_digit(c) || is_alpha(c) || c == CH_UNDER;
  endfunction

  function automatic bit is_print(input logic [7:0] c);
    return c >= CH_BANG && c <= CH_TILDE;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit find_name(output logic [5:0] k);
    bit hit;
    k = KIND_TEXT;
    if (tf.over || tok_len > PREFIX_LEN) return 1'b0;
    for (int i = 0; i < NAME_TOTAL; i++) begin
      if (reg_op_names[i].len() == tok_len) begin
        hit = 1'b1;
        for (int j = 0; j < tok_len; j++)
          if (reg_op_names[i][j] != prefix[j]) hit = 1'b0;
        if (hit) begin
          k = KIND_NAME_BASE + 6'(i);
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  task automatic note(input logic [5:0] k, input logic [15:0] st, input logic [7:0] ln,
                      input logic ok);
    res_word_t r;
    r = '{kind: k, token_start: st, token_length: ln, success: ok, last_of_run: 1'b0};
    step_out = {step_out, r};
  endtask

  task automatic clear_state();
    foreach (prefix[i]) prefix[i] = '0;
    tok_len = 0;
    tok_start = '0;
    char_pos = '0;
    tf = '0;
    in_tok = 1'b0;
    line_dead = 1'b0;
    line_used = 1'b0;
    after_label = 1'b0;
    err_seen = 1'b0;
  endtask

  task automatic grow_token(input logic [7:0] c);
    if (!in_tok) begin
      in_tok = 1'b1;
      tok_start = char_pos;
      tok_len = 0;
      tf = '0;
      tf.all_valid = 1'b1;
      tf.all_digit = 1'b1;
      tf.first_lbr = (c == CH_LBR);
      tf.first_alpha = is_alpha(c);
    end
    tf.pre_valid = tf.all_valid;
    tf.last_colon = (c == CH_COLON);
    tf.last_rbr = (c == CH_RBR);
    if (!is_word_char(c)) tf.all_valid = 1'b0;
    if (!is_digit(c)) tf.all_digit = 1'b0;
    if (tok_len < PREFIX_LEN) prefix[tok_len] = c;
    if (tok_len >= LEN_CAP) tf.over = 1'b1;
    else tok_len++;
  endtask

  task automatic close_token();
    logic [5:0] k;
    logic [5:0] nk;
    int ln;
    in_tok = 1'b0;
    ln = tok_len;
    if (tf.last_colon) begin
      if (tf.pre_valid) begin
        k = KIND_LABEL;
        if (!tf.over && ln > 0) ln--;
      end else begin
        k = KIND_ERROR;
      end
    end else if (tf.first_lbr && tf.last_rbr) begin
      k = find_name(nk) ? nk : KIND_ERROR;
    end else if (tf.all_digit) begin
      k = KIND_NUMBER;
    end else if (tf.first_alpha && tf.all_valid) begin
      k = find_name(nk) ? nk : KIND_TEXT;
    end else begin
      k = KIND_ERROR;
    end
    if (k == KIND_ERROR) err_seen = 1'b1;
    after_label = (k == KIND_LABEL);
    note(k, tok_start, ln[7:0], 1'b0);
  endtask

  task automatic close_line(input logic [15:0] p);
    in_tok = 1'b0;
    line_dead = 1'b0;
    line_used = 1'b0;
    if (!after_label) note(KIND_OPEND, p, 8'd0, 1'b0);
  endtask

  task automatic classify_word(input src_word_t w);
    logic [7:0] c;
    res_word_t r;
    c = w.char_code;
    step_out.delete();
    if (w.mode == MODE_END) begin
      if (!err_seen && in_tok) close_token();
      if (!err_seen && line_used) close_line(char_pos);
      note(KIND_END, char_pos, 8'd0, !err_seen);
      clear_state();
    end else begin
      if (!err_seen) begin
        line_used = 1'b1;
        if (line_dead) begin
          if (c == CH_LF) close_line(char_pos);
        end else if (is_print(c)) begin
          grow_token(c);
        end else begin
          if (in_tok) close_token();
          if (!err_seen) begin
            if (c == CH_LF) close_line(char_pos);
            else if (!is_blank(c)) line_dead = 1'b1;
          end
        end
      end
      char_pos = char_pos + 16'd1;
    end
    if (step_out.size() > 0) begin
      r = step_out[step_out.size() - 1];
      r.last_of_run = 1'b1;
      step_out[step_out.size() - 1] = r;
    end
  endtask

  task automatic send(input logic m, input logic [7:0] c, input bit typed = 1'b0,
                      input res_word_t typed_res = '0);
    src_word_t w;
    w.mode = m;
    w.char_code = c;
    if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_word <= w;
    do @(posedge clk); while (src_stall);
    classify_word(w);
    if (typed) token_queue = {token_queue, typed_res};
    else foreach (step_out[i]) token_queue = {token_queue, step_out[i]};
    if (counting) begin
      src_count++;
      if (src_count % 64 == 0)
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 8;
          default: gap_pct = 30;
        endcase
      if (src_count >= CALM_AT) calm = 1'b1;
    end
  endtask

  task automatic drain();
    src_valid <= 1'b0;
    while (token_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'("A") + 8'($urandom_range(0, 25));
    if ($urandom_range(0, 1) == 1) c = c | CASE_BIT;
    return c;
  endfunction

  function automatic logic [7:0] rand_word_char();
    case ($urandom_range(0, 5))
      0, 1: return 8'("0") + 8'($urandom_range(0, 9));
      2: return CH_UNDER;
      default: return rand_letter();
    endcase
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 4))
      0: return CH_TAB;
      1: return 8'h0B;
      2: return 8'h0C;
      3: return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] rand_unprintable();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (is_print(c) || is_blank(c)) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic make_token();
    int sel, n, idx;
    logic [7:0] c;
    tok_bytes.delete();
    sel = $urandom_range(0, 19);
    if (sel < 6) begin
      idx = $urandom_range(0, NAME_TOTAL - 1);
      for (int j = 0; j < reg_op_names[idx].len(); j++)
        tok_bytes = {tok_bytes, reg_op_names[idx][j]};
      if (sel == 0 && is_alpha(tok_bytes[0])) tok_bytes[0] = tok_bytes[0] ^ CASE_BIT;
      if (sel == 1) tok_bytes = {tok_bytes, rand_word_char()};
    end else if (sel < 9) begin
      n = $urandom_range(1, 6);
      repeat (n) tok_bytes = {tok_bytes, 8'("0") + 8'($urandom_range(0, 9))};
    end else if (sel < 12) begin
      tok_bytes = {tok_bytes, rand_letter()};
      n = $urandom_range(0, 7);
      repeat (n) tok_bytes = {tok_bytes, rand_word_char()};
    end else if (sel < 15) begin
      n = $urandom_range(0, 6);
      repeat (n) tok_bytes = {tok_bytes, rand_word_char()};
      tok_bytes = {tok_bytes, CH_COLON};
    end else if (sel < 17) begin
      tok_bytes = {tok_bytes, CH_LBR};
      case ($urandom_range(0, 4))
        0: tok_bytes = {tok_bytes, 8'("A")};
        1: tok_bytes = {tok_bytes, 8'("B")};
        2: tok_bytes = {tok_bytes, 8'("C")};
        3: begin
          tok_bytes = {tok_bytes, 8'("S")};
          tok_bytes = {tok_bytes, 8'("P")};
        end
        default: begin
          n = $urandom_range(1, 3);
          repeat (n) tok_bytes = {tok_bytes, rand_letter()};
        end
      endcase
      if ($urandom_range(0, 5) != 0) tok_bytes = {tok_bytes, CH_RBR};
    end else if (sel < 19) begin
      tok_bytes = {tok_bytes, rand_word_char()};
      c = 8'($urandom_range(CH_BANG, CH_TILDE));
      tok_bytes = {tok_bytes, c};
      tok_bytes = {tok_bytes, CH_COLON};
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) tok_bytes = {tok_bytes, 8'($urandom_range(CH_BANG, CH_TILDE))};
    end
  endtask

  task automatic make_line();
    int ntok, tail;
    logic [7:0] c;
    ntok = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) send(MODE_CHAR, rand_blank());
    for (int t = 0; t < ntok; t++) begin
      make_token();
      foreach (tok_bytes[i]) send(MODE_CHAR, tok_bytes[i]);
      if (t != ntok - 1) begin
        if ($urandom_range(0, 19) == 0) send(MODE_CHAR, rand_unprintable());
        repeat ($urandom_range(1, 2)) send(MODE_CHAR, rand_blank());
      end
    end
    case ($urandom_range(0, 9))
      0: begin
        send(MODE_CHAR, rand_unprintable());
        tail = $urandom_range(0, 3);
        repeat (tail) begin
          c = 8'($urandom_range(0, 255));
          if (c == CH_LF) c = CH_TOP;
          send(MODE_CHAR, c);
        end
        send(MODE_CHAR, CH_LF);
      end
      1: send(MODE_END, 8'($urandom_range(0, 255)));
      default: send(MODE_CHAR, CH_LF);
    endcase
  endtask

  // result side: stall bursts with a rate re-chosen whenever stall_phase wraps to zero
  int     stall_left = 0;
  int     stall_pct = 10;
  logic [7:0] stall_phase = '0;

  always @(posedge clk) begin
    stall_phase <= stall_phase + 8'd1;
    if (stall_phase == '0)
      case ($urandom_range(0, 2))
        0: stall_pct <= 0;
        1: stall_pct <= 10;
        default: stall_pct <= 35;
      endcase
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      res_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 15);
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    res_word_t want;
    if (!rst && res_valid && !res_stall) begin
      if (token_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result word: kind %0d start %0d len %0d ok %0b last %0b",
                   res_word.kind, res_word.token_start, res_word.token_length,
                   res_word.success, res_word.last_of_run);
      end else begin
        want = token_queue.pop_front();
        if (res_word.kind !== want.kind || res_word.token_start !== want.token_start ||
            res_word.token_length !== want.token_length ||
            res_word.success !== want.success || res_word.last_of_run !== want.last_of_run) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch: kind %0d/%0d start %0d/%0d len %0d/%0d ok %0b/%0b last %0b/%0b",
                     want.kind, res_word.kind, want.token_start, res_word.token_start,
                     want.token_length, res_word.token_length, want.success,
                     res_word.success, want.last_of_run, res_word.last_of_run);
        end
      end
    end
  end

  initial begin
    bit paused;
    paused = 1'b0;
    clear_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_ROWS; i++)
      send(PLAN[i].mode, PLAN[i].ch, PLAN[i].typed, PLAN[i].res);
    drain();

    // overlong label: length saturates, colon stays counted
    send(MODE_CHAR, "q");
    repeat (257) send(MODE_CHAR, rand_word_char());
    send(MODE_CHAR, CH_COLON);
    send(MODE_CHAR, CH_SPACE);
    send(MODE_CHAR, "7");
    send(MODE_CHAR, CH_LF);

    counting = 1'b1;
    while (src_count < RANDOM_ITEMS) begin
      make_line();
      if ($urandom_range(0, 4) == 0) send(MODE_END, 8'($urandom_range(0, 255)));
      if (!paused && src_count >= PAUSE_AT) begin
        drain();
        paused = 1'b1;
      end
    end
    send(MODE_END, 8'($urandom_range(0, 255)));
    calm = 1'b1;
    drain();

    if (mismatches == 0 && token_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
